// File: rtl/rupt_pkg.sv
// Package for the ranked unique population table.
// Holds operation and status codes and the cell bus types; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rupt_pkg;
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_REPLACE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_HOMOG   = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_DUP        = 3'd1;
    localparam logic [2:0] ST_NOT_BETTER = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_EMPTY      = 3'd4;
    localparam logic [2:0] ST_BAD_INDEX  = 3'd5;

    // Entry word handed between neighbouring cells.
    typedef struct packed {
        logic [63:0]        genes;
        logic signed [31:0] fitness;
    } rupt_entry_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic        shift_dn;  // cells past the insert position take the neighbour above
        logic        rot_up;    // every cell takes the neighbour below (read/scan)
        logic        load;      // cell at insert position takes candidate
    } rupt_cmd_t;
endpackage
`default_nettype wire

// File: rtl/rupt_cell.sv
// One storage cell of the ranked table chain.
// Depends on rupt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rupt_cell
    import rupt_pkg::*;
(
    input  wire logic        aclk,
    input  wire rupt_cmd_t   cmd,
    input  wire logic        sel,       // this cell is the insert target
    input  wire rupt_entry_t cand,
    input  wire rupt_entry_t from_up,   // cell at rank-1
    input  wire rupt_entry_t from_dn,   // cell at rank+1
    input  wire logic        shift_en,  // rank > insert position
    output rupt_entry_t      q
);
    rupt_entry_t q_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load && sel) begin
            q_reg <= cand;
        end else if (cmd.shift_dn && shift_en) begin
            q_reg <= from_up;
        end else if (cmd.rot_up) begin
            q_reg <= from_dn;
        end
    end

    assign q = q_reg;
endmodule
`default_nettype wire

// File: rtl/ranked_unique_population_table_core.sv
// Top level of the ranked unique population table.
// Depends on rupt_pkg and rupt_cell.
//
// Usage: one command transaction enters on the s_ stream and produces one
// result transaction on the m_ stream. The table is a chain of CAPACITY cells
// in rank order. Read, duplicate scan, rank search and column counting
// rotate the chain one cell per cycle past cell 0 in a single pass that
// restores the original order; an insertion then moves the tail down and
// loads the new entry. A homogeneity query then folds one column total per
// cycle into the numerator. One item at a time; the next transaction is
// taken in the cycle after the result leaves.
// Reset clears the entry count and control; cell contents stay undefined
// and are never shown before they are written.
// A stalled receiver holds the result in the output register; s_tready
// stays low until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module ranked_unique_population_table_core
    import rupt_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int GENE_BITS = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: genes[63:0], fitness[95:64], pseudo[96], rank_index[102:97]
    input  wire logic [103:0] s_tdata,
    // tuser: operation[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: position[5:0], entry_count[12:6], genes_out[76:13],
    // fitness_out[108:77], homog_numerator[121:109], homog_denominator[134:122]
    output logic [135:0]      m_tdata,
    // tuser: status[2:0]
    output logic [2:0]        m_tuser
);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int BW = $clog2(GENE_BITS + 1);
    localparam logic [63:0] GMASK = {64{1'b1}} >> (64 - GENE_BITS);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_SUM, S_INSERT, S_OUT
    } state_t;

    state_t      state_reg;
    logic [1:0]  op_reg;
    rupt_entry_t cand_reg;
    logic        pseudo_reg;
    logic [5:0]  rank_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] step_reg;   // rotation step, equals rank now at cell 0
    logic        dup_reg;
    logic [CW-1:0] pos_reg;    // first rank with fitness below candidate
    logic        pos_found_reg;
    logic [63:0] rd_genes_reg;
    logic [31:0] rd_fit_reg;
    logic signed [31:0] worst_reg;
    logic [CW-1:0] ones_reg [GENE_BITS];
    logic [BW-1:0] col_reg;    // column being folded into the numerator
    logic [2:0]  st_reg;
    logic [5:0]  opos_reg;
    logic [12:0] num_reg, den_reg;
    logic [CW-1:0] col_ones, col_rest;
    logic [12:0] col_term;

    rupt_cmd_t   cmd;
    rupt_entry_t q [CAPACITY];
    logic [IW-1:0] pos_idx;

    assign pos_idx = pos_reg[IW-1:0];
    assign cmd.rot_up   = (state_reg == S_SCAN);
    assign cmd.shift_dn = (state_reg == S_INSERT);
    assign cmd.load     = (state_reg == S_INSERT);

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        rupt_cell u_cell (
            .aclk     (aclk),
            .cmd      (cmd),
            .sel      (pos_idx == IW'(k)),
            .cand     (cand_reg),
            .from_up  (q[(k + CAPACITY - 1) % CAPACITY]),
            .from_dn  (q[(k + 1) % CAPACITY]),
            .shift_en (IW'(k) > pos_idx),
            .q        (q[k])
        );
    end

    // Contribution of the column now at the head of the totals.
    always_comb begin
        col_ones = ones_reg[0];
        col_rest = count_reg - col_ones;
        if (pseudo_reg) begin
            col_term = 13'((col_ones > col_rest) ? col_ones : col_rest);
        end else begin
            col_term = (col_ones == '0 || col_ones == count_reg) ? 13'd1 : 13'd0;
        end
    end

    logic in_range;
    assign in_range = step_reg < count_reg;
    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            m_tvalid  <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg         <= s_tuser;
                        cand_reg.genes <= s_tdata[63:0] & GMASK;
                        cand_reg.fitness <= s_tdata[95:64];
                        pseudo_reg     <= s_tdata[96];
                        rank_reg       <= s_tdata[102:97];
                        step_reg       <= '0;
                        dup_reg        <= 1'b0;
                        pos_reg        <= count_reg;
                        pos_found_reg  <= 1'b0;
                        rd_genes_reg   <= '0;
                        rd_fit_reg     <= '0;
                        for (int b = 0; b < GENE_BITS; b++) ones_reg[b] <= '0;
                        state_reg      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Cell 0 holds rank step_reg this cycle; rotate after.
                    if (in_range) begin
                        if (q[0].genes == cand_reg.genes) dup_reg <= 1'b1;
                        if (!pos_found_reg && q[0].fitness < cand_reg.fitness) begin
                            pos_reg       <= step_reg;
                            pos_found_reg <= 1'b1;
                        end
                        if (step_reg == count_reg - CW'(1)) worst_reg <= q[0].fitness;
                        if (step_reg == CW'(rank_reg)) begin
                            rd_genes_reg <= q[0].genes;
                            rd_fit_reg   <= q[0].fitness;
                        end
                        for (int b = 0; b < GENE_BITS; b++)
                            ones_reg[b] <= ones_reg[b] + CW'(q[0].genes[b]);
                    end
                    step_reg <= step_reg + CW'(1);
                    if (step_reg == CW'(CAPACITY - 1)) state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    st_reg   <= ST_OK;
                    opos_reg <= '0;
                    num_reg  <= '0;
                    den_reg  <= '0;
                    state_reg <= S_OUT;
                    case (op_reg)
                        OP_ADD: begin
                            if (dup_reg) st_reg <= ST_DUP;
                            else if (count_reg == CW'(CAPACITY)) st_reg <= ST_FULL;
                            else begin
                                opos_reg  <= 6'(pos_reg);
                                count_reg <= count_reg + CW'(1);
                                state_reg <= S_INSERT;
                            end
                        end
                        OP_REPLACE: begin
                            if (count_reg == '0) st_reg <= ST_EMPTY;
                            else if (!(worst_reg < cand_reg.fitness))
                                st_reg <= ST_NOT_BETTER;
                            else if (dup_reg) st_reg <= ST_DUP;
                            else begin
                                opos_reg  <= 6'(pos_reg);
                                state_reg <= S_INSERT;
                            end
                        end
                        OP_READ: begin
                            if (count_reg == '0) st_reg <= ST_EMPTY;
                            else if (32'(rank_reg) >= 32'(count_reg))
                                st_reg <= ST_BAD_INDEX;
                        end
                        default: begin
                            den_reg <= pseudo_reg ? 13'(GENE_BITS * count_reg)
                                                  : 13'(GENE_BITS);
                            col_reg   <= '0;
                            state_reg <= S_SUM;
                        end
                    endcase
                end
                S_SUM: begin
                    // Fold one column, then advance the totals by one place.
                    num_reg <= num_reg + col_term;
                    for (int b = 0; b < GENE_BITS - 1; b++)
                        ones_reg[b] <= ones_reg[b + 1];
                    col_reg <= col_reg + BW'(1);
                    if (col_reg == BW'(GENE_BITS - 1)) state_reg <= S_OUT;
                end
                S_INSERT: begin
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_tvalid) begin
                        m_tvalid <= 1'b1;
                        m_tuser  <= st_reg;
                        m_tdata  <= {1'b0, den_reg, num_reg,
                                     (op_reg == OP_READ && st_reg == ST_OK) ? rd_fit_reg : 32'd0,
                                     (op_reg == OP_READ && st_reg == ST_OK) ? rd_genes_reg : 64'd0,
                                     7'(count_reg), opos_reg};
                    end else if (m_tready) begin
                        m_tvalid  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/rupt_checker.sv
// Port checker for the ranked unique population table, bound to the top.
// Depends on rupt_pkg and ranked_unique_population_table_core.
`timescale 1ns / 1ps
`default_nettype none
module rupt_checker
    import rupt_pkg::*;
(
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [135:0] m_tdata,
    input wire logic [2:0]   m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted with result pending");
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= ST_BAD_INDEX)
        else $error("bad status code");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[12:6] <= 7'd64)
        else $error("count overflow");
endmodule

bind ranked_unique_population_table_core rupt_checker u_rupt_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire
